// File: src/svrp_pkg.sv
// ----------------------------------------------------------------------------
// svrp_pkg
// Shared types and constants for the RFC 4175 4:2:2 video RTP packetiser.
// ----------------------------------------------------------------------------
package svrp_pkg;

    // result kinds
    localparam logic [1:0] KIND_PKT  = 2'd0;
    localparam logic [1:0] KIND_HDR  = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;

    // register indexes
    localparam logic [1:0] REG_WIDTH   = 2'd0;
    localparam logic [1:0] REG_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_PAYLOAD = 2'd2;

    // segment planning
    localparam int MaxSegments = 10;
    localparam int SegIdxW     = 4;
    localparam logic [10:0] HdrBytes    = 11'd6;
    localparam logic [10:0] OpenMin     = 11'd11;   // header plus one pgroup
    localparam logic [12:0] RecipFive   = 13'd6554; // 2^15 / 5, rounded up
    localparam logic [10:0] PayloadMin  = 11'd64;
    localparam logic [10:0] PayloadMax  = 11'd1460;

    // effective frame settings
    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
        logic [10:0] payload;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic start;
        logic plan_step;
        logic emit_pkt;
        logic emit_hdr;
        logic emit_data;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pkt_due;
        logic plan_cont;
        logic hdr_last;
        logic out_free;
    } status_t;

endpackage

// File: src/st2110_video_rtp_packetizer_core.sv
// ----------------------------------------------------------------------------
// st2110_video_rtp_packetizer_core
// RFC 4175 packetiser for 4:2:2 pixel pairs sent as 10-bit pgroups.
//
//   channel      direction   handshake
//   pixel pair   in          in_valid / in_stall, one pixel pair per request
//   result       out         out_valid / out_stall, one data result per request
//   apb          in/out      psel, penable, pwrite, pready (always high)
//
// A pair with no packet start passes through accept, start and emit; its
// result is registered when it is emitted.
// A packet start adds one planner step per segment (up to 10) and emits
// one header result per segment plus one packet item before the data.
// Stalls on the output hold the sequencer; the next pair waits in_stall.
// Reset clears all positions and the sequence counter; no clearing pass.
// ----------------------------------------------------------------------------
module st2110_video_rtp_packetizer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  cb_sample,
    input  logic [7:0]  luma_first,
    input  logic [7:0]  cr_sample,
    input  logic [7:0]  luma_second,
    input  logic [31:0] frame_timestamp,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  item_kind,
    output logic [15:0] seq_number,
    output logic [31:0] rtp_timestamp,
    output logic        marker_bit,
    output logic [10:0] segment_length,
    output logic [14:0] segment_line,
    output logic [14:0] segment_offset,
    output logic        segment_continue,
    output logic [39:0] pgroup_word,
    output logic        end_of_packet,
    output logic        last_result
);

    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [10:0] payload_reg;
    logic        wr_en;
    logic [12:0] width_even;

    svrp_pkg::cfg_t    cfg;
    svrp_pkg::cmd_t    cmd;
    svrp_pkg::status_t status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= 13'd1920;
            height_reg  <= 13'd1080;
            payload_reg <= 11'd1428;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                svrp_pkg::REG_WIDTH:   width_reg   <= pwdata[12:0];
                svrp_pkg::REG_HEIGHT:  height_reg  <= pwdata[12:0];
                svrp_pkg::REG_PAYLOAD: payload_reg <= pwdata[10:0];
                default:               ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (paddr[3:2])
            svrp_pkg::REG_WIDTH:   prdata = {19'd0, width_reg};
            svrp_pkg::REG_HEIGHT:  prdata = {19'd0, height_reg};
            svrp_pkg::REG_PAYLOAD: prdata = {21'd0, payload_reg};
            default:               prdata = '0;
        endcase
    end

    // effective settings
    always_comb
    begin
        width_even  = {width_reg[12:1], 1'b0};
        cfg.width   = (width_even < 13'd2) ? 13'd2 : width_even;
        cfg.height  = (height_reg == '0) ? 13'd1 : height_reg;
        if (payload_reg < svrp_pkg::PayloadMin)
        begin
            cfg.payload = svrp_pkg::PayloadMin;
        end
        else if (payload_reg > svrp_pkg::PayloadMax)
        begin
            cfg.payload = svrp_pkg::PayloadMax;
        end
        else
        begin
            cfg.payload = payload_reg;
        end
    end

    svrp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    svrp_dp u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .cmd              (cmd),
        .status           (status),
        .cb_sample        (cb_sample),
        .luma_first       (luma_first),
        .cr_sample        (cr_sample),
        .luma_second      (luma_second),
        .frame_timestamp  (frame_timestamp),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .item_kind        (item_kind),
        .seq_number       (seq_number),
        .rtp_timestamp    (rtp_timestamp),
        .marker_bit       (marker_bit),
        .segment_length   (segment_length),
        .segment_line     (segment_line),
        .segment_offset   (segment_offset),
        .segment_continue (segment_continue),
        .pgroup_word      (pgroup_word),
        .end_of_packet    (end_of_packet),
        .last_result      (last_result)
    );

endmodule

// File: src/svrp_ctrl.sv
// ----------------------------------------------------------------------------
// svrp_ctrl
// Sequencer: takes a request, plans the packet when due, emits results.
// ----------------------------------------------------------------------------
module svrp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  svrp_pkg::status_t status,
    output svrp_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_PLAN  = 3'd2;
    localparam logic [2:0] ST_PKT   = 3'd3;
    localparam logic [2:0] ST_HDR   = 3'd4;
    localparam logic [2:0] ST_DATA  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_START;
                end
            end
            ST_START:
            begin
                cmd.start  = 1'b1;
                state_next = status.pkt_due ? ST_PLAN : ST_DATA;
            end
            ST_PLAN:
            begin
                cmd.plan_step = 1'b1;
                if (!status.plan_cont)
                begin
                    state_next = ST_PKT;
                end
            end
            ST_PKT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_pkt = 1'b1;
                    state_next   = ST_HDR;
                end
            end
            ST_HDR:
            begin
                if (status.out_free)
                begin
                    cmd.emit_hdr = 1'b1;
                    if (status.hdr_last)
                    begin
                        state_next = ST_DATA;
                    end
                end
            end
            ST_DATA:
            begin
                if (status.out_free)
                begin
                    cmd.emit_data = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/svrp_dp.sv
// ----------------------------------------------------------------------------
// svrp_dp
// Datapath: frame positions, segment planner, header slots, output register.
// ----------------------------------------------------------------------------
module svrp_dp
(
    input  logic               clk,
    input  logic               rst_n,
    input  svrp_pkg::cfg_t     cfg,
    input  svrp_pkg::cmd_t     cmd,
    output svrp_pkg::status_t  status,
    input  logic [7:0]         cb_sample,
    input  logic [7:0]         luma_first,
    input  logic [7:0]         cr_sample,
    input  logic [7:0]         luma_second,
    input  logic [31:0]        frame_timestamp,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         item_kind,
    output logic [15:0]        seq_number,
    output logic [31:0]        rtp_timestamp,
    output logic               marker_bit,
    output logic [10:0]        segment_length,
    output logic [14:0]        segment_line,
    output logic [14:0]        segment_offset,
    output logic               segment_continue,
    output logic [39:0]        pgroup_word,
    output logic               end_of_packet,
    output logic               last_result
);

    // captured request
    logic [39:0] pg_reg;
    logic [31:0] ts_in_reg;

    // frame state
    logic [15:0] seq_reg;
    logic [14:0] data_line_reg;
    logic [14:0] data_off_reg;
    logic [14:0] plan_line_reg;
    logic [14:0] plan_off_reg;
    logic [10:0] pairs_left_reg;
    logic [31:0] held_ts_reg;
    logic        in_frame_reg;

    // planner working state
    logic [10:0]                  left_reg;
    logic [10:0]                  pairs_acc_reg;
    logic [svrp_pkg::SegIdxW-1:0] cnt_reg;
    logic [svrp_pkg::SegIdxW-1:0] hdr_idx_reg;

    // header slots
    logic [10:0] slot_len_reg  [svrp_pkg::MaxSegments];
    logic [14:0] slot_line_reg [svrp_pkg::MaxSegments];
    logic [14:0] slot_off_reg  [svrp_pkg::MaxSegments];
    logic        slot_cont_reg [svrp_pkg::MaxSegments];

    // output register
    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [15:0] seq_o_reg;
    logic [31:0] ts_o_reg;
    logic        marker_reg;
    logic [10:0] len_o_reg;
    logic [14:0] line_o_reg;
    logic [14:0] off_o_reg;
    logic        cont_o_reg;
    logic [39:0] pg_o_reg;
    logic        eop_reg;
    logic        last_reg;

    // output register next values
    logic [1:0]  kind_next;
    logic [15:0] seq_o_next;
    logic [31:0] ts_o_next;
    logic        marker_next;
    logic [10:0] len_o_next;
    logic [14:0] line_o_next;
    logic [14:0] off_o_next;
    logic        cont_o_next;
    logic [39:0] pg_o_next;
    logic        eop_next;
    logic        last_next;

    logic [14:0] width_x;
    logic [14:0] height_x;
    logic        out_free;

    // packet start fix-ups
    logic [14:0] fix_line;
    logic [14:0] fix_off;
    logic        fix_restart;

    // segment step
    logic [10:0] left_a;
    logic [13:0] pix_full;
    logic [15:0] len_full;
    logic [23:0] recip_prod;
    logic [8:0]  quot;
    logic        fits;
    logic [10:0] seg_len;
    logic [13:0] seg_pix;
    logic [10:0] left_n;
    logic [14:0] line_n;
    logic [14:0] off_n;
    logic        seg_cont;
    logic [svrp_pkg::SegIdxW-1:0] cnt_n;

    // data position step
    logic [10:0] pairs_dec;
    logic [14:0] doff_n;
    logic [14:0] dline_n;
    logic        dwrap;
    logic        dend;

    assign width_x  = {2'b00, cfg.width};
    assign height_x = {2'b00, cfg.height};
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        fix_line = plan_line_reg;
        fix_off  = plan_off_reg;
        if (plan_off_reg >= width_x)
        begin
            fix_off  = '0;
            fix_line = plan_line_reg + 15'd1;
        end
        fix_restart = fix_line >= height_x;
    end

    always_comb
    begin
        left_a     = left_reg - svrp_pkg::HdrBytes;
        pix_full   = 14'(width_x - plan_off_reg);
        len_full   = ({2'b00, pix_full} * 16'd5) >> 1;
        recip_prod = {13'd0, left_a} * {11'd0, svrp_pkg::RecipFive};
        quot       = recip_prod[23:15];
        fits       = {5'd0, left_a} >= len_full;
        seg_len    = fits ? len_full[10:0] : 11'({2'b00, quot} * 11'd5);
        seg_pix    = fits ? pix_full : {4'd0, quot, 1'b0};
        left_n     = left_a - seg_len;
        line_n     = fits ? plan_line_reg + 15'd1 : plan_line_reg;
        off_n      = fits ? 15'd0 : plan_off_reg + {1'b0, seg_pix};
        cnt_n      = cnt_reg + 1'b1;
        seg_cont   = (left_n > svrp_pkg::OpenMin) && (line_n < height_x)
                     && (cnt_n < svrp_pkg::SegIdxW'(svrp_pkg::MaxSegments));
    end

    always_comb
    begin
        pairs_dec = (pairs_left_reg != '0) ? pairs_left_reg - 11'd1 : pairs_left_reg;
        doff_n    = data_off_reg + 15'd2;
        dwrap     = doff_n >= width_x;
        dline_n   = data_line_reg + 15'd1;
        dend      = dwrap && (dline_n >= height_x);
    end

    assign status.pkt_due   = pairs_left_reg == '0;
    assign status.plan_cont = seg_cont;
    assign status.hdr_last  = hdr_idx_reg == cnt_reg - 1'b1;
    assign status.out_free  = out_free;

    // captured pair and timestamp
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            pg_reg    <= {cb_sample, 2'b00, luma_first, 2'b00,
                          cr_sample, 2'b00, luma_second, 2'b00};
            ts_in_reg <= frame_timestamp;
        end
    end

    // header slot writes
    always_ff @(posedge clk)
    begin
        if (cmd.plan_step)
        begin
            slot_len_reg[cnt_reg]  <= seg_len;
            slot_line_reg[cnt_reg] <= plan_line_reg;
            slot_off_reg[cnt_reg]  <= plan_off_reg;
            slot_cont_reg[cnt_reg] <= seg_cont;
        end
    end

    // frame and planner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg        <= '0;
            data_line_reg  <= '0;
            data_off_reg   <= '0;
            plan_line_reg  <= '0;
            plan_off_reg   <= '0;
            pairs_left_reg <= '0;
            held_ts_reg    <= '0;
            in_frame_reg   <= 1'b0;
            left_reg       <= '0;
            pairs_acc_reg  <= '0;
            cnt_reg        <= '0;
            hdr_idx_reg    <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                if (pairs_left_reg == '0)
                begin
                    left_reg      <= cfg.payload - 11'd2;
                    pairs_acc_reg <= '0;
                    cnt_reg       <= '0;
                    if (fix_restart)
                    begin
                        data_line_reg <= '0;
                        data_off_reg  <= '0;
                        plan_line_reg <= '0;
                        plan_off_reg  <= '0;
                    end
                    else
                    begin
                        plan_line_reg <= fix_line;
                        plan_off_reg  <= fix_off;
                    end
                    if (!in_frame_reg || fix_restart)
                    begin
                        held_ts_reg <= ts_in_reg;
                    end
                end
                else if (!in_frame_reg)
                begin
                    held_ts_reg <= ts_in_reg;
                end
                in_frame_reg <= 1'b1;
            end
            if (cmd.plan_step)
            begin
                left_reg      <= left_n;
                plan_line_reg <= line_n;
                plan_off_reg  <= off_n;
                pairs_acc_reg <= pairs_acc_reg + seg_pix[11:1];
                cnt_reg       <= cnt_n;
            end
            if (cmd.emit_pkt)
            begin
                seq_reg        <= seq_reg + 16'd1;
                pairs_left_reg <= pairs_acc_reg;
                hdr_idx_reg    <= '0;
            end
            if (cmd.emit_hdr)
            begin
                hdr_idx_reg <= hdr_idx_reg + 1'b1;
            end
            if (cmd.emit_data)
            begin
                pairs_left_reg <= pairs_dec;
                if (dend)
                begin
                    data_line_reg <= '0;
                    data_off_reg  <= '0;
                    plan_line_reg <= '0;
                    plan_off_reg  <= '0;
                    in_frame_reg  <= 1'b0;
                end
                else if (dwrap)
                begin
                    data_off_reg  <= '0;
                    data_line_reg <= dline_n;
                end
                else
                begin
                    data_off_reg <= doff_n;
                end
            end
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_pkt || cmd.emit_hdr || cmd.emit_data)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload selection, fields of other kinds held at zero
    always_comb
    begin
        kind_next   = svrp_pkg::KIND_DATA;
        seq_o_next  = '0;
        ts_o_next   = '0;
        marker_next = 1'b0;
        len_o_next  = '0;
        line_o_next = '0;
        off_o_next  = '0;
        cont_o_next = 1'b0;
        pg_o_next   = '0;
        eop_next    = 1'b0;
        last_next   = 1'b0;
        if (cmd.emit_pkt)
        begin
            kind_next   = svrp_pkg::KIND_PKT;
            seq_o_next  = seq_reg + 16'd1;
            ts_o_next   = held_ts_reg;
            marker_next = plan_line_reg >= height_x;
        end
        else if (cmd.emit_hdr)
        begin
            kind_next   = svrp_pkg::KIND_HDR;
            len_o_next  = slot_len_reg[hdr_idx_reg];
            line_o_next = slot_line_reg[hdr_idx_reg];
            off_o_next  = slot_off_reg[hdr_idx_reg];
            cont_o_next = slot_cont_reg[hdr_idx_reg];
        end
        else
        begin
            pg_o_next = pg_reg;
            eop_next  = pairs_dec == '0;
            last_next = 1'b1;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_pkt || cmd.emit_hdr || cmd.emit_data)
        begin
            kind_reg   <= kind_next;
            seq_o_reg  <= seq_o_next;
            ts_o_reg   <= ts_o_next;
            marker_reg <= marker_next;
            len_o_reg  <= len_o_next;
            line_o_reg <= line_o_next;
            off_o_reg  <= off_o_next;
            cont_o_reg <= cont_o_next;
            pg_o_reg   <= pg_o_next;
            eop_reg    <= eop_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign item_kind        = kind_reg;
    assign seq_number       = seq_o_reg;
    assign rtp_timestamp    = ts_o_reg;
    assign marker_bit       = marker_reg;
    assign segment_length   = len_o_reg;
    assign segment_line     = line_o_reg;
    assign segment_offset   = off_o_reg;
    assign segment_continue = cont_o_reg;
    assign pgroup_word      = pg_o_reg;
    assign end_of_packet    = eop_reg;
    assign last_result      = last_reg;

endmodule
